@@ rtl/core/usesc_pkg.sv @@
package usesc_pkg;

   // Longest escape of one character: backslash, u, brace, eight digits, brace.
   localparam int RUN_DEPTH = 12;
   localparam int RUN_CNT_W = 4;

   // Escape table selection.
   localparam logic [2:0] MODE_PLAIN  = 3'd0;
   localparam logic [2:0] MODE_SINGLE = 3'd1;
   localparam logic [2:0] MODE_DOUBLE = 3'd2;
   localparam logic [2:0] MODE_BACK   = 3'd3;
   localparam logic [2:0] MODE_URL    = 3'd4;

   // Characters used by the escape forms.
   localparam logic [7:0] CH_BSLASH  = 8'h5c;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LOW_X   = 8'h78;
   localparam logic [7:0] CH_LOW_U   = 8'h75;
   localparam logic [7:0] CH_LBRACE  = 8'h7b;
   localparam logic [7:0] CH_RBRACE  = 8'h7d;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_BQUOTE  = 8'h60;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_ESC     = 8'h1b;
   localparam logic [7:0] CH_DEL     = 8'h7f;

   typedef logic [7:0] char_type;
   typedef char_type [RUN_DEPTH-1:0] run_chars_type;

   // One decoded character, or a mark, handed from the decoder to the formatter.
   typedef struct packed {
      logic        emit;
      logic        multi;
      logic        err;
      logic        str_last;
      logic [30:0] code;
   } dec_result_type;

   function automatic char_type hex_lo(input logic [3:0] nib);
      char_type ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h57 + {4'd0, nib};
      end
      return ch;
   endfunction

   function automatic char_type hex_up(input logic [3:0] nib);
      char_type ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h37 + {4'd0, nib};
      end
      return ch;
   endfunction

endpackage

@@ rtl/core/usesc_decoder.sv @@
module usesc_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [7:0]               in_byte,
   input  logic                     last,
   output usesc_pkg::dec_result_type result
);

   logic [30:0] pc_ff, pc_in;
   logic [2:0]  pend_ff, pend_in;
   logic [2:0]  seq_ff, seq_in;
   logic        halted_ff, halted_in;

   logic [2:0]  lead_len;
   logic [7:0]  lead_mask;
   logic [30:0] pc_next;
   logic [30:0] min_code;
   usesc_pkg::dec_result_type res;

   // Continuation byte count from the lead byte; zero marks an invalid lead.
   always_comb begin
      priority if (in_byte[7:5] == 3'b110) begin
         lead_len = 3'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
         lead_len = 3'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
         lead_len = 3'd3;
      end else if (in_byte[7:2] == 6'b111110) begin
         lead_len = 3'd4;
      end else if (in_byte[7:1] == 7'b1111110) begin
         lead_len = 3'd5;
      end else begin
         lead_len = 3'd0;
      end
   end

   // Payload bits of the lead byte.
   always_comb begin
      unique case (lead_len)
         3'd1:    lead_mask = 8'h1f;
         3'd2:    lead_mask = 8'h0f;
         3'd3:    lead_mask = 8'h07;
         3'd4:    lead_mask = 8'h03;
         3'd5:    lead_mask = 8'h01;
         default: lead_mask = 8'h00;
      endcase
   end

   // Smallest code that a sequence of this length may carry.
   always_comb begin
      unique case (seq_ff)
         3'd1:    min_code = 31'h80;
         3'd2:    min_code = 31'h800;
         3'd3:    min_code = 31'h10000;
         3'd4:    min_code = 31'h200000;
         3'd5:    min_code = 31'h4000000;
         default: min_code = 31'h0;
      endcase
   end

   assign pc_next = {pc_ff[24:0], in_byte[5:0]};

   // Decode one byte against the pending sequence.
   always_comb begin
      pc_in        = pc_ff;
      pend_in      = pend_ff;
      seq_in       = seq_ff;
      halted_in    = halted_ff;
      res          = '0;
      res.str_last = last;
      res.code     = {23'd0, in_byte};
      if (halted_ff) begin
         res.err = last;
      end else if (pend_ff == 3'd0) begin
         if (!in_byte[7]) begin
            res.emit = 1'b1;
         end else if (lead_len == 3'd0 || last) begin
            res.err = 1'b1;
         end else begin
            pc_in   = {23'd0, in_byte & lead_mask};
            pend_in = lead_len;
            seq_in  = lead_len;
         end
      end else if (in_byte[7:6] != 2'b10) begin
         res.err = 1'b1;
      end else begin
         pc_in   = pc_next;
         pend_in = pend_ff - 3'd1;
         if (pend_ff == 3'd1) begin
            if (pc_next < min_code) begin
               res.err = 1'b1;
            end else begin
               res.emit  = 1'b1;
               res.multi = 1'b1;
               res.code  = pc_next;
            end
         end else if (last) begin
            res.err = 1'b1;
         end
      end
      if (res.err) begin
         halted_in = 1'b1;
         pend_in   = 3'd0;
      end
      if (last) begin
         pc_in     = '0;
         pend_in   = 3'd0;
         seq_in    = 3'd0;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         pend_ff   <= 3'd0;
         seq_ff    <= 3'd0;
         halted_ff <= 1'b0;
      end else if (advance) begin
         pc_ff     <= pc_in;
         pend_ff   <= pend_in;
         seq_ff    <= seq_in;
         halted_ff <= halted_in;
      end
   end

   assign result = res;

endmodule

@@ rtl/core/usesc_format.sv @@
module usesc_format (
   input  usesc_pkg::dec_result_type             dec,
   input  logic [2:0]                            mode,
   output usesc_pkg::run_chars_type              chars,
   output logic [usesc_pkg::RUN_CNT_W-1:0]       count
);

   typedef enum logic [2:0] {
      ESC_RAW    = 3'd0,
      ESC_LETTER = 3'd1,
      ESC_PCT    = 3'd2,
      ESC_X      = 3'd3,
      ESC_U      = 3'd4
   } esc_kind_type;

   esc_kind_type         kind;
   usesc_pkg::char_type  letter;
   usesc_pkg::char_type  c;
   logic [2:0]           m;
   logic [3:0]           digits;
   logic [3:0]           brace_idx;

   function automatic logic [3:0] nibble(input logic [30:0] v, input logic [2:0] k);
      logic [31:0] shifted;
      shifted = {1'b0, v} >> {k, 2'b00};
      return shifted[3:0];
   endfunction

   function automatic usesc_pkg::char_type ctl_letter(input logic [2:0] idx);
      usesc_pkg::char_type ch;
      unique case (idx)
         3'd0:    ch = 8'h62;
         3'd1:    ch = 8'h74;
         3'd2:    ch = 8'h6e;
         3'd3:    ch = 8'h76;
         3'd4:    ch = 8'h66;
         3'd5:    ch = 8'h72;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   assign c = dec.code[7:0];
   assign m = (mode > usesc_pkg::MODE_URL) ? usesc_pkg::MODE_PLAIN : mode;

   // Escape class of a one-byte character under the selected table.
   always_comb begin
      kind   = ESC_RAW;
      letter = c;
      if (m == usesc_pkg::MODE_URL) begin
         if (c < 8'h20 || c == usesc_pkg::CH_DEL) begin
            kind = ESC_PCT;
         end else if (c == usesc_pkg::CH_BSLASH) begin
            kind = ESC_LETTER;
         end
      end else if (c < 8'h20) begin
         if (c >= 8'h08 && c <= 8'h0d) begin
            if (!(m == usesc_pkg::MODE_BACK && (c == 8'h0a || c == 8'h0d))) begin
               kind   = ESC_LETTER;
               letter = ctl_letter(c[2:0]);
            end
         end else begin
            kind = ESC_X;
         end
      end else if (c == usesc_pkg::CH_BSLASH) begin
         kind = ESC_LETTER;
      end else if (c == usesc_pkg::CH_DEL) begin
         kind = (m == usesc_pkg::MODE_PLAIN) ? ESC_X : ESC_U;
      end else if ((m == usesc_pkg::MODE_SINGLE && c == usesc_pkg::CH_SQUOTE) ||
                   (m == usesc_pkg::MODE_DOUBLE && c == usesc_pkg::CH_DQUOTE) ||
                   (m == usesc_pkg::MODE_BACK &&
                    (c == usesc_pkg::CH_BQUOTE || c == usesc_pkg::CH_DOLLAR))) begin
         kind = ESC_LETTER;
      end
   end

   // Number of hex digits of a code above sixteen bits.
   always_comb begin
      priority if (dec.code[30:28] != 3'd0) begin
         digits = 4'd8;
      end else if (dec.code[27:24] != 4'd0) begin
         digits = 4'd7;
      end else if (dec.code[23:20] != 4'd0) begin
         digits = 4'd6;
      end else begin
         digits = 4'd5;
      end
   end

   assign brace_idx = 4'd3 + digits;

   // Build the run of characters for this byte.
   always_comb begin
      chars = '0;
      count = '0;
      if (dec.emit && !dec.multi) begin
         unique case (kind)
            ESC_PCT: begin
               chars[0] = usesc_pkg::CH_PERCENT;
               chars[1] = usesc_pkg::hex_up(c[7:4]);
               chars[2] = usesc_pkg::hex_up(c[3:0]);
               count    = 4'd3;
            end
            ESC_U: begin
               chars[0] = usesc_pkg::CH_BSLASH;
               chars[1] = usesc_pkg::CH_LOW_U;
               chars[2] = usesc_pkg::CH_ZERO;
               chars[3] = usesc_pkg::CH_ZERO;
               chars[4] = usesc_pkg::hex_lo(c[7:4]);
               chars[5] = usesc_pkg::hex_lo(c[3:0]);
               count    = 4'd6;
            end
            ESC_X: begin
               chars[0] = usesc_pkg::CH_BSLASH;
               chars[1] = usesc_pkg::CH_LOW_X;
               chars[2] = usesc_pkg::hex_lo(c[7:4]);
               chars[3] = usesc_pkg::hex_lo(c[3:0]);
               count    = 4'd4;
            end
            ESC_LETTER: begin
               chars[0] = usesc_pkg::CH_BSLASH;
               chars[1] = letter;
               count    = 4'd2;
            end
            default: begin
               chars[0] = c;
               count    = 4'd1;
            end
         endcase
      end else if (dec.emit) begin
         chars[0] = usesc_pkg::CH_BSLASH;
         if (dec.code[30:8] == 23'd0) begin
            chars[1] = usesc_pkg::CH_LOW_X;
            chars[2] = usesc_pkg::hex_lo(dec.code[7:4]);
            chars[3] = usesc_pkg::hex_lo(dec.code[3:0]);
            count    = 4'd4;
         end else if (dec.code[30:16] == 15'd0) begin
            chars[1] = usesc_pkg::CH_LOW_U;
            chars[2] = usesc_pkg::hex_lo(dec.code[15:12]);
            chars[3] = usesc_pkg::hex_lo(dec.code[11:8]);
            chars[4] = usesc_pkg::hex_lo(dec.code[7:4]);
            chars[5] = usesc_pkg::hex_lo(dec.code[3:0]);
            count    = 4'd6;
         end else begin
            chars[1] = usesc_pkg::CH_LOW_U;
            chars[2] = usesc_pkg::CH_LBRACE;
            for (int j = 0; j < 8; j++) begin
               if (j < int'(digits)) begin
                  chars[3 + j] = usesc_pkg::hex_up(nibble(dec.code, 3'(int'(digits) - 1 - j)));
               end
            end
            chars[brace_idx] = usesc_pkg::CH_RBRACE;
            count            = brace_idx + 4'd1;
         end
      end else if (dec.err || dec.str_last) begin
         // Bare error or end mark.
         count = 4'd1;
      end
   end

endmodule

@@ rtl/core/utf8_string_escaper_unit.sv @@
// Channel   Direction  Ports                                   Moves
// req       in         req_valid/req_ready, req_in_byte,       one string byte per word
//                      req_last_byte
// rsp       out        rsp_valid/rsp_ready, rsp_out_char, ...  one escaped character or mark
// csr       in         csr_valid/csr_ready, csr_quote_mode     escape table select
//
// A byte is registered at acceptance and decoded and escaped into the run buffer once the
// buffer is free, where its first result word appears on rsp. A byte that yields several
// result words holds the run buffer until its last word is taken, so bytes follow back to
// back while each yields at most one word and rsp does not stall; bytes that yield no word
// do not hold the run buffer. Reset clears the decoder state, the quote mode and both valid
// flags. A stall on rsp holds the run buffer and backs up into the input.
module utf8_string_escaper_unit (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end,
   output logic       rsp_decode_error,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_quote_mode
);

   logic [2:0]  mode_ff;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   usesc_pkg::run_chars_type              chars_ff, chars_in, fmt_chars;
   logic [usesc_pkg::RUN_CNT_W-1:0]       cnt_ff, cnt_in, fmt_count;
   logic                                  run_chars_ff, run_err_ff, run_end_ff;

   logic run_free;
   logic consume;
   logic req_take;
   logic rsp_take;

   usesc_pkg::dec_result_type dec;

   // Configuration register, always writable.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= usesc_pkg::MODE_PLAIN;
      end else if (csr_valid) begin
         mode_ff <= csr_quote_mode;
      end
   end

   // Handshake control between the input register and the run buffer.
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign run_free  = (cnt_ff == '0) || (cnt_ff == 4'd1 && rsp_ready);
   assign consume   = in_valid_ff && run_free;
   assign req_ready = !in_valid_ff || run_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_byte;
      end
   end

   usesc_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .advance (consume),
      .in_byte (in_byte_ff),
      .last    (in_last_ff),
      .result  (dec)
   );

   usesc_format u_format (
      .dec   (dec),
      .mode  (mode_ff),
      .chars (fmt_chars),
      .count (fmt_count)
   );

   // Run buffer: load a new run, or shift one word out per accepted result.
   always_comb begin
      chars_in = chars_ff;
      cnt_in   = cnt_ff;
      if (consume) begin
         chars_in = fmt_chars;
         cnt_in   = fmt_count;
      end else if (rsp_take) begin
         for (int i = 0; i < usesc_pkg::RUN_DEPTH - 1; i++) begin
            chars_in[i] = chars_ff[i + 1];
         end
         chars_in[usesc_pkg::RUN_DEPTH - 1] = '0;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      if (consume) begin
         run_chars_ff <= dec.emit;
         run_err_ff   <= dec.err;
         run_end_ff   <= dec.str_last;
      end
   end

   // Result word from the head of the run buffer.
   assign rsp_out_char     = chars_ff[0];
   assign rsp_char_valid   = run_chars_ff;
   assign rsp_decode_error = run_err_ff;
   assign rsp_run_last     = (cnt_ff == 4'd1);
   assign rsp_string_end   = run_end_ff && (cnt_ff == 4'd1);

endmodule

@@ verif/tb_top.sv @@
module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int PHASE_ITEMS    = 50;
   localparam int RANDOM_PHASES  = 10;
   localparam int REPORT_LIMIT   = 10;

   // Quote mode codes that select no table of their own.
   localparam logic [2:0] MODE_RSVD_5 = 3'd5;
   localparam logic [2:0] MODE_RSVD_6 = 3'd6;
   localparam logic [2:0] MODE_RSVD_7 = 3'd7;

   // Characters the escape tables look at or produce.
   localparam logic [7:0] NO_ESCAPE  = 8'h00;
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_BACKSP  = 8'h08;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_VT      = 8'h0b;
   localparam logic [7:0] CH_FF      = 8'h0c;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_B   = 8'h62;
   localparam logic [7:0] CH_LOW_T   = 8'h74;
   localparam logic [7:0] CH_LOW_N   = 8'h6e;
   localparam logic [7:0] CH_LOW_V   = 8'h76;
   localparam logic [7:0] CH_LOW_F   = 8'h66;
   localparam logic [7:0] CH_LOW_R   = 8'h72;
   localparam logic [7:0] CH_TILDE   = 8'h7e;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       ch_valid;
      logic       run_last;
      logic       str_end;
      logic       dec_err;
   } escaped_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last_byte = 1'b0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_char_valid;
   logic       rsp_run_last;
   logic       rsp_string_end;
   logic       rsp_decode_error;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_quote_mode = usesc_pkg::MODE_PLAIN;

   // Stimulus queues, the expected words, and the words of the byte being predicted.
   text_byte_type    text_q[$];
   logic [7:0]       string_buf_q[$];
   logic [2:0]       cfg_q[$];
   escaped_word_type escaped_q[$];
   escaped_word_type byte_run_q[$];

   // Predictor copy of the configuration and the decoder state.
   logic [2:0]  esc_mode = usesc_pkg::MODE_PLAIN;
   logic [30:0] dec_code = '0;
   logic [2:0]  dec_pending = '0;
   logic [2:0]  dec_seqlen = '0;
   logic        dec_halted = 1'b0;

   int req_gap = 0;
   int rsp_stall = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int mismatch_cnt = 0;
   int idle_cycles = 0;

   escaped_word_type seen_word;
   escaped_word_type want_word;

   utf8_string_escaper_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_end   (rsp_string_end),
      .rsp_decode_error (rsp_decode_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_quote_mode   (csr_quote_mode)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A gap is drawn with the given percent chance; about one in ten drawn gaps is long.
   function automatic int draw_gap(input int pct);
      if ($urandom_range(0, 99) >= pct) begin
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Smallest code point that a sequence with this many continuation bytes may carry.
   function automatic logic [31:0] utf8_floor(input int len);
      case (len)
         1:       return 32'h80;
         2:       return 32'h800;
         3:       return 32'h10000;
         4:       return 32'h200000;
         default: return 32'h4000000;
      endcase
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) begin
         return usesc_pkg::CH_ZERO + {4'd0, nib};
      end
      return (upper ? CH_UP_A : CH_LOW_A) + {4'd0, nib} - 8'd10;
   endfunction

   function automatic void put_char(input logic [7:0] ch);
      byte_run_q.push_back('{ch: ch, ch_valid: 1'b1, run_last: 1'b0, str_end: 1'b0,
                             dec_err: 1'b0});
   endfunction

   function automatic void put_hex(input logic [31:0] value, input int digits, input bit upper);
      for (int i = digits - 1; i >= 0; i--) begin
         put_char(nibble_char(value[4*i +: 4], upper));
      end
   endfunction

   // Escape one decoded character into byte_run_q.
   function automatic void render_char(input logic [30:0] c, input bit multi);
      logic [2:0] m;
      logic [7:0] c7;
      logic [7:0] esc;
      int         d;
      m = (esc_mode > usesc_pkg::MODE_URL) ? usesc_pkg::MODE_PLAIN : esc_mode;
      c7 = {1'b0, c[6:0]};
      esc = NO_ESCAPE;
      d = 1;
      if (multi) begin
         if (c <= 31'hff) begin
            put_char(usesc_pkg::CH_BSLASH);
            put_char(usesc_pkg::CH_LOW_X);
            put_hex({1'b0, c}, 2, 1'b0);
         end else if (c <= 31'hffff) begin
            put_char(usesc_pkg::CH_BSLASH);
            put_char(usesc_pkg::CH_LOW_U);
            put_hex({1'b0, c}, 4, 1'b0);
         end else begin
            // Braced form: uppercase digits without leading zeros.
            while (d < 8 && ({1'b0, c} >> (4 * d)) != 0) begin
               d++;
            end
            put_char(usesc_pkg::CH_BSLASH);
            put_char(usesc_pkg::CH_LOW_U);
            put_char(usesc_pkg::CH_LBRACE);
            put_hex({1'b0, c}, d, 1'b1);
            put_char(usesc_pkg::CH_RBRACE);
         end
         return;
      end

      // Table lookup for a one-byte character.
      if (m == usesc_pkg::MODE_URL) begin
         if (c7 < CH_SPACE || c7 == usesc_pkg::CH_DEL) begin
            esc = usesc_pkg::CH_PERCENT;
         end else if (c7 == usesc_pkg::CH_BSLASH) begin
            esc = usesc_pkg::CH_BSLASH;
         end
      end else if (c7 < CH_SPACE) begin
         case (c7)
            CH_BACKSP: esc = CH_LOW_B;
            CH_TAB:    esc = CH_LOW_T;
            CH_LF:     esc = (m == usesc_pkg::MODE_BACK) ? NO_ESCAPE : CH_LOW_N;
            CH_VT:     esc = CH_LOW_V;
            CH_FF:     esc = CH_LOW_F;
            CH_CR:     esc = (m == usesc_pkg::MODE_BACK) ? NO_ESCAPE : CH_LOW_R;
            default:   esc = usesc_pkg::CH_LOW_X;
         endcase
      end else if (c7 == usesc_pkg::CH_BSLASH) begin
         esc = usesc_pkg::CH_BSLASH;
      end else if (c7 == usesc_pkg::CH_DEL) begin
         esc = (m == usesc_pkg::MODE_PLAIN) ? usesc_pkg::CH_LOW_X : usesc_pkg::CH_LOW_U;
      end else if ((m == usesc_pkg::MODE_SINGLE && c7 == usesc_pkg::CH_SQUOTE) ||
                   (m == usesc_pkg::MODE_DOUBLE && c7 == usesc_pkg::CH_DQUOTE) ||
                   (m == usesc_pkg::MODE_BACK &&
                    (c7 == usesc_pkg::CH_BQUOTE || c7 == usesc_pkg::CH_DOLLAR))) begin
         esc = c7;
      end

      if (esc == usesc_pkg::CH_PERCENT) begin
         put_char(usesc_pkg::CH_PERCENT);
         put_hex({24'd0, c7}, 2, 1'b1);
      end else if (esc == usesc_pkg::CH_LOW_U) begin
         put_char(usesc_pkg::CH_BSLASH);
         put_char(usesc_pkg::CH_LOW_U);
         put_hex({24'd0, c7}, 4, 1'b0);
      end else if (esc == usesc_pkg::CH_LOW_X || c7 == usesc_pkg::CH_ESC) begin
         // The escape character always takes the hex form outside url mode.
         put_char(usesc_pkg::CH_BSLASH);
         put_char(usesc_pkg::CH_LOW_X);
         put_hex({24'd0, c7}, 2, 1'b0);
      end else if (esc != NO_ESCAPE) begin
         put_char(usesc_pkg::CH_BSLASH);
         put_char(esc);
      end else begin
         put_char(c7);
      end
   endfunction

   // Decode one string byte and queue the words it should produce.
   function automatic void escape_byte(input logic [7:0] b, input logic last);
      logic err;
      int   len;
      err = 1'b0;
      len = 0;
      byte_run_q.delete();
      if (dec_halted) begin
         // After a decode error only the last byte of the string gives a word.
         if (!last) begin
            return;
         end
         err = 1'b1;
      end else if (dec_pending == 0) begin
         if (b < 8'h80) begin
            render_char({23'd0, b}, 1'b0);
         end else begin
            if (b >= 8'hc0 && b <= 8'hdf) begin
               len = 1;
            end else if (b >= 8'he0 && b <= 8'hef) begin
               len = 2;
            end else if (b >= 8'hf0 && b <= 8'hf7) begin
               len = 3;
            end else if (b >= 8'hf8 && b <= 8'hfb) begin
               len = 4;
            end else if (b >= 8'hfc && b <= 8'hfd) begin
               len = 5;
            end
            if (len == 0 || last) begin
               err = 1'b1;
            end else begin
               dec_code = {23'd0, b & (8'hff >> (len + 2))};
               dec_pending = 3'(len);
               dec_seqlen = 3'(len);
            end
         end
      end else if (b < 8'h80 || b >= 8'hc0) begin
         err = 1'b1;
      end else begin
         dec_code = {dec_code[24:0], b[5:0]};
         dec_pending = dec_pending - 3'd1;
         if (dec_pending == 0) begin
            // Overlong forms are rejected.
            if ({1'b0, dec_code} < utf8_floor(int'(dec_seqlen))) begin
               err = 1'b1;
            end else begin
               render_char(dec_code, 1'b1);
            end
         end else if (last) begin
            err = 1'b1;
         end
      end

      if (err) begin
         dec_halted = 1'b1;
         dec_pending = '0;
         byte_run_q.push_back('{ch: 8'h00, ch_valid: 1'b0, run_last: 1'b0, str_end: 1'b0,
                                dec_err: 1'b1});
      end
      if (last && byte_run_q.size() == 0) begin
         byte_run_q.push_back('{ch: 8'h00, ch_valid: 1'b0, run_last: 1'b0, str_end: 1'b0,
                                dec_err: 1'b0});
      end
      if (byte_run_q.size() != 0) begin
         byte_run_q[byte_run_q.size() - 1].run_last = 1'b1;
         if (last) begin
            byte_run_q[byte_run_q.size() - 1].str_end = 1'b1;
         end
      end
      if (last) begin
         dec_code = '0;
         dec_pending = '0;
         dec_seqlen = '0;
         dec_halted = 1'b0;
      end
      foreach (byte_run_q[i]) begin
         escaped_q.push_back(byte_run_q[i]);
      end
   endfunction

   function automatic string word_text(input escaped_word_type w);
      return $sformatf("char %02h cv %0d rl %0d end %0d err %0d",
                       w.ch, w.ch_valid, w.run_last, w.str_end, w.dec_err);
   endfunction

   function automatic void log_mismatch(input string what, input escaped_word_type want,
                                        input escaped_word_type got);
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT) begin
         $display("%0t %s: expected %s, got %s", $realtime, what, word_text(want),
                  word_text(got));
      end
   endfunction

   function automatic void stage(input logic [7:0] b);
      string_buf_q.push_back(b);
   endfunction

   // Encode a code point in the given number of continuation bytes.
   function automatic void stage_utf8(input logic [31:0] code, input int len);
      stage(~(8'hff >> (len + 1)) | 8'(code >> (6 * len)));
      for (int i = len - 1; i >= 0; i--) begin
         stage(8'h80 | (8'(code >> (6 * i)) & 8'h3f));
      end
   endfunction

   // Short sequences are the common case.
   function automatic int draw_seq_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 1;
      if (r < 75) return 2;
      if (r < 87) return 3;
      if (r < 95) return 4;
      return 5;
   endfunction

   // Move the staged string to the driver, marking its final byte.
   function automatic void flush_string();
      foreach (string_buf_q[i]) begin
         text_q.push_back('{data: string_buf_q[i], last: (i == string_buf_q.size() - 1)});
      end
      string_buf_q.delete();
   endfunction

   // A string of random characters, mostly well formed, some broken.
   function automatic int build_random_string();
      int          counted;
      int          nchars;
      int          sel;
      int          len;
      int          start;
      bit          cut_short;
      logic [31:0] code_top;
      logic [31:0] code;
      logic [7:0]  ch;
      counted = 0;
      cut_short = 1'b0;
      nchars = $urandom_range(1, 8);
      for (int k = 0; k < nchars; k++) begin
         start = string_buf_q.size();
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            // Plain characters, half of them from a list of special and boundary characters.
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 18))
                  0:       ch = CH_NUL;
                  1:       ch = CH_BACKSP;
                  2:       ch = CH_TAB;
                  3:       ch = CH_LF;
                  4:       ch = CH_VT;
                  5:       ch = CH_FF;
                  6:       ch = CH_CR;
                  7:       ch = usesc_pkg::CH_ESC;
                  8:       ch = CH_SPACE;
                  9:       ch = usesc_pkg::CH_DQUOTE;
                  10:      ch = usesc_pkg::CH_DOLLAR;
                  11:      ch = usesc_pkg::CH_SQUOTE;
                  12:      ch = usesc_pkg::CH_BSLASH;
                  13:      ch = usesc_pkg::CH_BQUOTE;
                  14:      ch = usesc_pkg::CH_DEL;
                  15:      ch = CH_UP_A;
                  16:      ch = CH_TILDE;
                  17:      ch = CH_SPACE - 8'd1;
                  default: ch = usesc_pkg::CH_PERCENT;
               endcase
            end else begin
               ch = 8'($urandom_range(0, 127));
            end
            stage(ch);
         end else if (sel < 85) begin
            len = draw_seq_len();
            code_top = (32'd1 << (5 * len + 6)) - 32'd1;
            case ($urandom_range(0, 4))
               0:       code = utf8_floor(len);
               1:       code = code_top;
               default: code = $urandom_range(code_top, utf8_floor(len));
            endcase
            stage_utf8(code, len);
         end else begin
            len = draw_seq_len();
            code = $urandom_range((32'd1 << (5 * len + 6)) - 32'd1, utf8_floor(len));
            case ($urandom_range(0, 3))
               0: begin
                  // Stray byte from the upper half.
                  stage(8'($urandom_range(8'h80, 8'hff)));
               end
               1: begin
                  // Bad continuation byte somewhere in the sequence.
                  stage_utf8(code, len);
                  string_buf_q[start + $urandom_range(1, len)] =
                     ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 8'h7f))
                                                 : 8'($urandom_range(8'hc0, 8'hff));
               end
               2: begin
                  // Overlong form.
                  len = $urandom_range(1, 5);
                  stage_utf8($urandom_range(utf8_floor(len) - 32'd1, 0), len);
               end
               default: begin
                  // Sequence cut off by the end of the string.
                  stage_utf8(code, len);
                  repeat ($urandom_range(1, len)) begin
                     void'(string_buf_q.pop_back());
                  end
                  cut_short = 1'b1;
               end
            endcase
         end
         counted += string_buf_q.size() - start;
         if (cut_short) begin
            break;
         end
      end
      flush_string();
      return counted;
   endfunction

   // Driver: feeds string bytes and register writes, and predicts each accepted word.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         req_gap = 0;
         esc_mode = usesc_pkg::MODE_PLAIN;
         dec_code = '0;
         dec_pending = '0;
         dec_seqlen = '0;
         dec_halted = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            esc_mode = csr_quote_mode;
            csr_valid <= 1'b0;
         end else if (!csr_valid && cfg_q.size() != 0) begin
            csr_quote_mode <= cfg_q.pop_front();
            csr_valid <= 1'b1;
         end

         if (req_valid && req_ready) begin
            escape_byte(req_in_byte, req_last_byte);
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (text_q.size() != 0) begin
               req_in_byte <= text_q[0].data;
               req_last_byte <= text_q[0].last;
               void'(text_q.pop_front());
               req_valid <= 1'b1;
               req_gap = draw_gap(req_idle_pct);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result word against the oldest expectation and stalls rsp.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word = '{ch: rsp_out_char, ch_valid: rsp_char_valid, run_last: rsp_run_last,
                       str_end: rsp_string_end, dec_err: rsp_decode_error};
         if (escaped_q.size() == 0) begin
            log_mismatch("unexpected word", '0, seen_word);
         end else begin
            want_word = escaped_q.pop_front();
            if (seen_word !== want_word) begin
               log_mismatch("word mismatch", want_word, seen_word);
            end
         end
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = draw_gap(rsp_idle_pct);
      end
   end

   // Watchdog on cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Wait until every byte, write and expected word is through, then let the pipeline empty.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (text_q.size() != 0 || req_valid || escaped_q.size() != 0 ||
                 cfg_q.size() != 0 || csr_valid);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int phase_items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed strings in plain mode: control and special characters first.
      stage(CH_NUL);
      stage(CH_LF);
      stage(usesc_pkg::CH_ESC);
      stage(usesc_pkg::CH_BSLASH);
      stage(usesc_pkg::CH_DEL);
      flush_string();
      // One character each with one, two, three and five continuation bytes, up to the largest code point.
      stage_utf8(32'h80, 1);
      flush_string();
      stage_utf8(32'h800, 2);
      flush_string();
      stage_utf8(32'h10ffff, 3);
      flush_string();
      stage_utf8(32'h7fffffff, 5);
      flush_string();
      // Overlong form, invalid lead byte, and a sequence cut off by the end.
      stage_utf8(32'h0, 1);
      flush_string();
      stage(8'hff);
      flush_string();
      stage(8'he0);
      stage(8'ha0);
      flush_string();
      wait_drained();

      // Random phases, each under a quote mode and idle pattern chosen for it.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       cfg_q.push_back(usesc_pkg::MODE_PLAIN);
            1:       cfg_q.push_back(usesc_pkg::MODE_SINGLE);
            2:       cfg_q.push_back(usesc_pkg::MODE_DOUBLE);
            3:       cfg_q.push_back(usesc_pkg::MODE_BACK);
            4:       cfg_q.push_back(usesc_pkg::MODE_URL);
            5:       cfg_q.push_back(MODE_RSVD_5);
            6:       cfg_q.push_back(MODE_RSVD_7);
            7:       cfg_q.push_back(MODE_RSVD_6);
            8:       cfg_q.push_back(usesc_pkg::MODE_URL);
            default: cfg_q.push_back(usesc_pkg::MODE_BACK);
         endcase
         wait_drained();
         req_idle_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 70);
         rsp_idle_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 70);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            phase_items += build_random_string();
         end
         wait_drained();
      end

      if (mismatch_cnt == 0 && escaped_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/usesc_pkg.sv
rtl/core/usesc_decoder.sv
rtl/core/usesc_format.sv
rtl/core/utf8_string_escaper_unit.sv
verif/tb_top.sv
